[design/mcr_pkg.sv]
package mcr_pkg;

  localparam int RAD_W   = 12;
  localparam int GRAY_W  = 16;
  localparam int VAL_W   = 8;
  localparam int SX_W    = 13;
  localparam int SY_W    = 14;
  localparam int DEC_W   = 20;
  localparam int CFG_W   = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] CANVAS_WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] CANVAS_HEIGHT_RST = 13'd480;

  localparam int DEC_INIT   = 3;
  localparam int DEC_DIAG   = 10;
  localparam int DEC_STRAIT = 6;
  localparam int GRAY_MAX   = 255;

  typedef struct packed {
    logic                   idle;
    logic                   done;
    logic [VAL_W-1:0]       value;
    logic [SX_W-1:0]        sx;
    logic signed [SY_W-1:0] sy;
  } mcr_step_t;

endpackage

[design/mcr_queue.sv]
module mcr_queue #(
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              not_full,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] head_data
);
  localparam int DEPTH = 2;

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;

  assign not_full  = (count_r != 2'(DEPTH));
  assign not_empty = (count_r != 2'd0);
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'(DEPTH)) else $error("queue count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (not_full || pop)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty) else $error("pop from empty queue");

endmodule

[design/mcr_front.sv]
module mcr_front #(
  parameter int COORD_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_accept,
  input  logic                          in_func,
  input  logic signed [COORD_BITS-1:0]  in_cx,
  input  logic signed [COORD_BITS-1:0]  in_cy,
  input  logic [mcr_pkg::RAD_W-1:0]     in_radius,
  input  logic signed [mcr_pkg::GRAY_W-1:0] in_gray,
  output logic signed [COORD_BITS-1:0]  job_cx,
  output logic signed [COORD_BITS-1:0]  job_cy,
  output mcr_pkg::mcr_step_t            job_step
);
  import mcr_pkg::*;

  logic [SX_W-1:0]         sx_r, sx_nxt;
  logic signed [SY_W-1:0]  sy_r, sy_nxt;
  logic signed [DEC_W-1:0] dec_r, dec_nxt;
  logic signed [COORD_BITS-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic [VAL_W-1:0]        val_r, val_nxt;
  logic                    active_r, active_nxt;

  logic [SX_W-1:0]         x1;
  logic signed [SY_W-1:0]  y1;
  logic signed [DEC_W-1:0] xe, ye;
  logic [VAL_W-1:0]        clamp;
  logic                    done;

  always_comb begin
    if ($signed(in_gray) >= $signed(GRAY_W'(GRAY_MAX))) begin
      clamp = VAL_W'(GRAY_MAX);
    end else if (in_gray[GRAY_W-1] || in_gray == '0) begin
      clamp = '0;
    end else begin
      clamp = in_gray[VAL_W-1:0];
    end
  end

  always_comb begin
    x1 = sx_r + SX_W'(1);
    y1 = (dec_r > 0) ? sy_r - SY_W'(1) : sy_r;
    xe = $signed({{(DEC_W-SX_W){1'b0}}, x1});
    ye = DEC_W'(y1);
    done = $signed({1'b0, x1}) > y1;

    sx_nxt = sx_r;
    sy_nxt = sy_r;
    dec_nxt = dec_r;
    cx_nxt = cx_r;
    cy_nxt = cy_r;
    val_nxt = val_r;
    active_nxt = active_r;

    job_step.idle = 1'b0;
    job_step.done = 1'b0;

    if (in_func == FUNC_START) begin
      sx_nxt = '0;
      sy_nxt = $signed({{(SY_W-RAD_W){1'b0}}, in_radius});
      dec_nxt = DEC_W'(DEC_INIT) - $signed({{(DEC_W-RAD_W-1){1'b0}}, in_radius, 1'b0});
      cx_nxt = in_cx;
      cy_nxt = in_cy;
      val_nxt = clamp;
      active_nxt = 1'b1;
    end else if (active_r) begin
      sx_nxt = x1;
      sy_nxt = y1;
      if (dec_r > 0) begin
        dec_nxt = dec_r + ((xe - ye) <<< 2) + DEC_W'(DEC_DIAG);
      end else begin
        dec_nxt = dec_r + (xe <<< 2) + DEC_W'(DEC_STRAIT);
      end
      active_nxt = !done;
      job_step.done = done;
    end else begin
      job_step.idle = 1'b1;
      job_step.done = 1'b1;
    end

    job_step.value = val_nxt;
    job_step.sx = sx_nxt;
    job_step.sy = sy_nxt;
    job_cx = cx_nxt;
    job_cy = cy_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0;
      sy_r <= '0;
      dec_r <= '0;
      cx_r <= '0;
      cy_r <= '0;
      val_r <= '0;
      active_r <= 1'b0;
    end else if (in_accept) begin
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
      dec_r <= dec_nxt;
      cx_r <= cx_nxt;
      cy_r <= cy_nxt;
      val_r <= val_nxt;
      active_r <= active_nxt;
    end
  end

  a_active_octant: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> ($signed({1'b0, sx_r}) <= sy_r))
    else $error("active circle left its octant");

endmodule

[design/mcr_back.sv]
module mcr_back #(
  parameter int COORD_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mcr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [mcr_pkg::CFG_W-1:0]     cfg_val,
  input  logic                          q_valid,
  input  logic signed [COORD_BITS-1:0]  q_cx,
  input  logic signed [COORD_BITS-1:0]  q_cy,
  input  mcr_pkg::mcr_step_t            q_step,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_BITS:0]    out_px,
  output logic signed [COORD_BITS:0]    out_py,
  output logic [mcr_pkg::VAL_W-1:0]     out_val,
  output logic                          out_we,
  output logic                          out_last,
  output logic                          out_done
);
  import mcr_pkg::*;

  localparam int SW = ((COORD_BITS > SY_W) ? COORD_BITS : SY_W) + 2;

  logic [CFG_W-1:0] cw_r, ch_r;
  logic [2:0]       cnt_r, cnt_nxt;
  logic             vld_r, vld_nxt;
  logic signed [COORD_BITS:0] px_r, py_r;
  logic [VAL_W-1:0] val_r;
  logic             we_r, last_r, done_r;

  logic             load;
  logic signed [SW-1:0] ax, ay, a, b, pxf, pyf;
  logic             in_x, in_y, pt_last;

  always_comb begin
    load = q_valid && (!vld_r || out_ready);
    ax = $signed({{(SW-SX_W){1'b0}}, q_step.sx});
    ay = SW'(q_step.sy);
    a = cnt_r[2] ? ay : ax;
    b = cnt_r[2] ? ax : ay;
    pxf = SW'(q_cx) + (cnt_r[0] ? -a : a);
    pyf = SW'(q_cy) + (cnt_r[1] ? -b : b);
    in_x = !pxf[SW-1] && (pxf < $signed({{(SW-CFG_W){1'b0}}, cw_r}));
    in_y = !pyf[SW-1] && (pyf < $signed({{(SW-CFG_W){1'b0}}, ch_r}));
    pt_last = q_step.idle || (cnt_r == 3'd7);
    q_pop = load && pt_last;
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = pt_last ? 3'd0 : cnt_r + 3'd1;
    end
    vld_nxt = load ? 1'b1 : (out_ready ? 1'b0 : vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r <= CANVAS_WIDTH_RST;
      ch_r <= CANVAS_HEIGHT_RST;
      cnt_r <= '0;
      vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_CANVAS_WIDTH:  cw_r <= cfg_val;
          REG_CANVAS_HEIGHT: ch_r <= cfg_val;
          default: ;
        endcase
      end
      cnt_r <= cnt_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (q_step.idle) begin
        px_r <= '0;
        py_r <= '0;
        val_r <= '0;
        we_r <= 1'b0;
      end else begin
        px_r <= pxf[COORD_BITS:0];
        py_r <= pyf[COORD_BITS:0];
        val_r <= q_step.value;
        we_r <= in_x && in_y;
      end
      last_r <= pt_last;
      done_r <= pt_last && q_step.done;
    end
  end

  assign out_valid = vld_r;
  assign out_px = px_r;
  assign out_py = py_r;
  assign out_val = val_r;
  assign out_we = we_r;
  assign out_last = last_r;
  assign out_done = done_r;

  a_mid_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 3'd0) |-> q_valid) else $error("job left queue mid-sequence");
  a_idle_single: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_step.idle) |-> (cnt_r == 3'd0))
    else $error("idle job inside a point sequence");
  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (vld_r && last_r)) else $error("pop without last point");

endmodule

[design/midpoint_circle_rasterizer.sv]
// Midpoint circle outline generator. A start item (tuser 0) loads center, radius and a gray
// level clamped to 0..255 and yields the eight symmetric points of offset (0, radius); each
// advance item (tuser 1) does one midpoint step and yields eight more points, the eighth of the
// final step flagged circle_done. An advance with no circle in progress yields a single dummy
// point with write_enable low. Items are classified and stepped combinationally, then queued
// two deep; the point emitter drives one point per cycle, while a job waits and out_tready is
// high, through a registered output that sets the sustained rate. Points outside the
// configured canvas come out with write_enable low. Write the canvas size only while idle.
module midpoint_circle_rasterizer #(
  parameter int COORD_BITS = 14
) (
  input  logic clk,
  input  logic rst_n,
  // tdata, low bit up: center col, center row, radius, gray_value, zero pad
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [((2*COORD_BITS+28+7)/8)*8-1:0] in_tdata,
  // tuser: func
  input  logic                     in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // tdata, low bit up: pixel_x, pixel_y, pixel_value, zero pad
  output logic [((2*COORD_BITS+10+7)/8)*8-1:0] out_tdata,
  // tuser, low bit up: write_enable, circle_done
  output logic [1:0]               out_tuser,
  output logic                     out_tlast,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [mcr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcr_pkg::CFG_W-1:0]     cfg_data
);
  import mcr_pkg::*;

  localparam int OUT_W = ((2*COORD_BITS+10+7)/8)*8;
  localparam int PIX_W = COORD_BITS + 1;
  localparam int JOB_W = 2*COORD_BITS + $bits(mcr_step_t);
  localparam int IN_USED  = 2*COORD_BITS + RAD_W + GRAY_W;
  localparam int OUT_USED = 2*PIX_W + VAL_W;

  logic in_accept;
  logic signed [COORD_BITS-1:0] f_cx, f_cy, q_cx, q_cy;
  mcr_step_t f_step, q_step;
  logic [JOB_W-1:0] q_head;
  logic q_not_full, q_not_empty, q_pop;
  logic signed [PIX_W-1:0] px, py;
  logic [VAL_W-1:0] pval;
  logic pwe, pdone;

  assign cfg_ready = 1'b1;
  assign in_tready = q_not_full;
  assign in_accept = in_tvalid && q_not_full;

  mcr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_func   (in_tuser),
    .in_cx     ($signed(in_tdata[COORD_BITS-1:0])),
    .in_cy     ($signed(in_tdata[2*COORD_BITS-1:COORD_BITS])),
    .in_radius (in_tdata[2*COORD_BITS+RAD_W-1:2*COORD_BITS]),
    .in_gray   ($signed(in_tdata[IN_USED-1:2*COORD_BITS+RAD_W])),
    .job_cx    (f_cx),
    .job_cy    (f_cy),
    .job_step  (f_step)
  );

  mcr_queue #(.DATA_W(JOB_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data ({f_cx, f_cy, f_step}),
    .not_full  (q_not_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_data (q_head)
  );

  assign q_cx   = $signed(q_head[JOB_W-1:JOB_W-COORD_BITS]);
  assign q_cy   = $signed(q_head[JOB_W-COORD_BITS-1:$bits(mcr_step_t)]);
  assign q_step = mcr_step_t'(q_head[$bits(mcr_step_t)-1:0]);

  mcr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_val   (cfg_data),
    .q_valid   (q_not_empty),
    .q_cx      (q_cx),
    .q_cy      (q_cy),
    .q_step    (q_step),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_px    (px),
    .out_py    (py),
    .out_val   (pval),
    .out_we    (pwe),
    .out_last  (out_tlast),
    .out_done  (pdone)
  );

  assign out_tdata = {{(OUT_W-OUT_USED){1'b0}}, pval, py, px};
  assign out_tuser = {pdone, pwe};

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import mcr_pkg::*;

  localparam int CB = 14;
  localparam int IN_W = ((2*CB+28+7)/8)*8;
  localparam int OUT_W = ((2*CB+10+7)/8)*8;
  localparam int QUIET_LIMIT = 2000;
  localparam int ENDLESS = 100000;

  typedef struct packed {
    logic [CB:0]      x;
    logic [CB:0]      y;
    logic [VAL_W-1:0] val;
    logic             we;
    logic             last;
    logic             done;
  } pixel_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  midpoint_circle_rasterizer #(.COORD_BITS(CB)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // circle generator state as the block should hold it
  int canvas_w = int'(CANVAS_WIDTH_RST);
  int canvas_h = int'(CANVAS_HEIGHT_RST);
  int off_x = 0;
  int off_y = 0;
  int dvar = 0;
  int ctr_col = 0;
  int ctr_row = 0;
  logic [VAL_W-1:0] gray_hold = '0;
  bit drawing = 1'b0;

  pixel_t pending_pixels[$];
  pixel_t want;
  int errors = 0;
  int n_sent = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void add_point(int px, int py, bit lst, bit dn);
    pixel_t p;
    p.x = px[CB:0];
    p.y = py[CB:0];
    p.val = gray_hold;
    p.we = px >= 0 && py >= 0 && px < canvas_w && py < canvas_h;
    p.last = lst;
    p.done = dn;
    pending_pixels.push_back(p);
  endfunction

  function automatic void add_octants(bit dn);
    add_point(ctr_col + off_x, ctr_row + off_y, 1'b0, 1'b0);
    add_point(ctr_col - off_x, ctr_row + off_y, 1'b0, 1'b0);
    add_point(ctr_col + off_x, ctr_row - off_y, 1'b0, 1'b0);
    add_point(ctr_col - off_x, ctr_row - off_y, 1'b0, 1'b0);
    add_point(ctr_col + off_y, ctr_row + off_x, 1'b0, 1'b0);
    add_point(ctr_col - off_y, ctr_row + off_x, 1'b0, 1'b0);
    add_point(ctr_col + off_y, ctr_row - off_x, 1'b0, 1'b0);
    add_point(ctr_col - off_y, ctr_row - off_x, 1'b1, dn);
  endfunction

  function automatic void predict_points(logic op, logic [CB-1:0] cx, logic [CB-1:0] cy,
                                         logic [RAD_W-1:0] r, logic [GRAY_W-1:0] g);
    int gv;
    pixel_t p;
    if (op == FUNC_START) begin
      ctr_col = int'($signed(cx));
      ctr_row = int'($signed(cy));
      gv = int'($signed(g));
      gray_hold = VAL_W'(gv >= GRAY_MAX ? GRAY_MAX : (gv <= 0 ? 0 : gv));
      off_x = 0;
      off_y = int'(r);
      dvar = DEC_INIT - 2 * off_y;
      drawing = 1'b1;
      add_octants(1'b0);
    end else if (!drawing) begin
      p = '0;
      p.last = 1'b1;
      p.done = 1'b1;
      pending_pixels.push_back(p);
    end else begin
      off_x++;
      if (dvar > 0) begin
        off_y--;
        dvar = dvar + 4 * (off_x - off_y) + DEC_DIAG;
      end else begin
        dvar = dvar + 4 * off_x + DEC_STRAIT;
      end
      if (off_y < off_x) drawing = 1'b0;
      add_octants(!drawing);
    end
  endfunction

  task automatic send_item(logic op, int cx, int cy, int r, int g);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {GRAY_W'(g), RAD_W'(r), CB'(cy), CB'(cx)};
    do @(posedge clk); while (!in_tready);
    n_sent++;
    predict_points(op, CB'(cx), CB'(cy), RAD_W'(r), GRAY_W'(g));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  task automatic set_canvas(int w, int h);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= REG_CANVAS_WIDTH;
    cfg_data <= CFG_W'(w);
    do @(posedge clk); while (!cfg_ready);
    canvas_w = w;
    cfg_index <= REG_CANVAS_HEIGHT;
    cfg_data <= CFG_W'(h);
    do @(posedge clk); while (!cfg_ready);
    canvas_h = h;
    cfg_valid <= 1'b0;
  endtask

  task automatic draw_circle(int cx, int cy, int r, int g, int max_steps);
    int steps;
    steps = 0;
    send_item(FUNC_START, cx, cy, r, g);
    while (drawing && steps < max_steps) begin
      send_item(FUNC_ADVANCE, $urandom, $urandom, $urandom, $urandom);
      steps++;
    end
  endtask

  task automatic test_directed();
    send_item(FUNC_ADVANCE, 0, 0, 0, 0);
    draw_circle(0, 0, 0, 0, ENDLESS);
    send_item(FUNC_ADVANCE, -1, -1, 4095, -1);
    // abandon a huge circle mid-flight
    draw_circle(-8192, 8191, 4095, -32768, 2);
    draw_circle(8191, -8192, 1, 32767, ENDLESS);
    draw_circle(5, 5, 5, 255, ENDLESS);
    draw_circle(639, 479, 3, 256, ENDLESS);
    draw_circle(100, 100, 7, 254, ENDLESS);
  endtask

  task automatic test_canvas_extremes();
    int wl[5] = '{0, 1, 4096, 8191, 1};
    int hl[5] = '{0, 1, 4096, 8191, 4096};
    for (int i = 0; i < 5; i++) begin
      set_canvas(wl[i], hl[i]);
      draw_circle(0, 0, 2, 100, ENDLESS);
      draw_circle(wl[i] - 1, hl[i] - 1, 3, 77, ENDLESS);
    end
  endtask

  task automatic test_random_phase(int n, int w, int h, int sp, int rp);
    int first, pick, rsel, r, cx, cy, g, lim;
    set_canvas(w, h);
    send_idle_pct = sp;
    recv_stall_pct = rp;
    first = n_sent;
    while (n_sent - first < n) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        rsel = $urandom_range(99);
        r = rsel < 70 ? $urandom_range(12) : (rsel < 90 ? $urandom_range(64, 13)
                                                         : $urandom_range(4095));
        if ($urandom_range(99) < 85) begin
          cx = int'($urandom_range(canvas_w + 40)) - 20;
          cy = int'($urandom_range(canvas_h + 40)) - 20;
        end else begin
          cx = $urandom;
          cy = $urandom;
        end
        g = $urandom_range(99) < 60 ? int'($urandom_range(300)) - 20 : int'($urandom);
        lim = (r <= 12 && $urandom_range(99) < 85) ? ENDLESS : $urandom_range(12);
        draw_circle(cx, cy, r, g, lim);
        if ($urandom_range(99) < 20)
          send_item(FUNC_ADVANCE, $urandom, $urandom, $urandom, $urandom);
      end else begin
        send_item(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic cmp(string fld, int want_v, int got_v);
    if (want_v != got_v) begin
      errors++;
      if (errors <= 50)
        $display("%0t %s mismatch: expected %0d actual %0d", $time, fld, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t unexpected item: expected none actual tdata=%h tuser=%b tlast=%b",
                   $time, out_tdata, out_tuser, out_tlast);
      end else begin
        want = pending_pixels.pop_front();
        cmp("pixel_x", int'(want.x), int'(out_tdata[CB:0]));
        cmp("pixel_y", int'(want.y), int'(out_tdata[2*CB+1:CB+1]));
        cmp("pixel_value", int'(want.val), int'(out_tdata[2*CB+2+VAL_W-1:2*CB+2]));
        cmp("write_enable", int'(want.we), int'(out_tuser[0]));
        cmp("circle_done", int'(want.done), int'(out_tuser[1]));
        cmp("last", int'(want.last), int'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (rst_n)
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t watchdog: no progress", $time);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_canvas_extremes();
    test_random_phase(90, 640, 480, 0, 0);
    test_random_phase(90, $urandom_range(4096, 1), $urandom_range(4096, 1), 48, 0);
    test_random_phase(90, 96, 72, 0, 48);
    test_random_phase(90, 300, 200, 11, 11);
    wait_drained();
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
